FILE: src/lcrl_pkg.sv
`timescale 1ns / 1ps
package lcrl_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int ELEM_BITS = 32;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int LEN_W     = 11;

    localparam logic [1:0] CMD_APPEND_A = 2'd0;
    localparam logic [1:0] CMD_APPEND_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE  = 2'd2;

    typedef struct packed {
        logic append_a;
        logic append_b;
        logic start;
        logic step;
        logic finish;
    } lcrl_cmd_t;

    typedef struct packed {
        logic seq_empty;
        logic cell_last;
        logic pipe_busy;
    } lcrl_status_t;

endpackage

FILE: src/lcrl_ram.sv
`timescale 1ns / 1ps
module lcrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/lcrl_ctrl.sv
`timescale 1ns / 1ps
module lcrl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           cmd,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lcrl_pkg::lcrl_cmd_t  ctl,
    input  lcrl_pkg::lcrl_status_t sts
);
    import lcrl_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    // A compute waits while the previous result is still pending.
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && cmd == CMD_COMPUTE);
    assign accept   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctl            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_APPEND_A: ctl.append_a = 1'b1;
                        CMD_APPEND_B: ctl.append_b = 1'b1;
                        CMD_COMPUTE:
                        begin
                            ctl.start  = 1'b1;
                            state_next = sts.seq_empty ? S_DRAIN : S_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN:
            begin
                ctl.step = 1'b1;
                if (sts.cell_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    ctl.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/lcrl_datapath.sv
`timescale 1ns / 1ps
module lcrl_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [31:0]          value,
    input  lcrl_pkg::lcrl_cmd_t         ctl,
    output lcrl_pkg::lcrl_status_t      sts,
    output logic [lcrl_pkg::LEN_W-1:0]  match_length,
    output logic                        dropped
);
    import lcrl_pkg::*;

    logic [CNT_W-1:0]     a_count_reg, a_count_next;
    logic [CNT_W-1:0]     b_count_reg, b_count_next;
    logic                 flag_reg, flag_next;
    logic [ADDR_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]    col_reg, col_next;
    logic                 cell_valid_reg;
    logic [ADDR_W-1:0]    cell_col_reg;
    logic                 cell_first_row_reg;
    logic [CNT_W-1:0]     best_reg, best_next;
    logic [LEN_W-1:0]     match_length_reg;
    logic                 dropped_reg;
    logic                 fwd_hit_reg;
    logic [CNT_W-1:0]     fwd_data_reg;

    logic                 a_we, b_we;
    logic [ELEM_BITS-1:0] a_rd, b_rd;
    logic [CNT_W-1:0]     prev_rd;
    logic [CNT_W-1:0]     prev_val;
    logic [CNT_W-1:0]     diag;
    logic [CNT_W-1:0]     cell_value;

    assign a_we = ctl.append_a && (a_count_reg < CNT_W'(MAX_LEN));
    assign b_we = ctl.append_b && (b_count_reg < CNT_W'(MAX_LEN));

    lcrl_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_LEN)) u_seq_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_count_reg[ADDR_W-1:0]),
        .wdata (value[ELEM_BITS-1:0]),
        .raddr (row_reg),
        .rdata (a_rd)
    );

    lcrl_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_LEN)) u_seq_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_count_reg[ADDR_W-1:0]),
        .wdata (value[ELEM_BITS-1:0]),
        .raddr (col_reg),
        .rdata (b_rd)
    );

    // Columns are walked from high to low, so the diagonal entry read here
    // still belongs to the previous row when the cell is formed.
    lcrl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_prev_row (
        .clk   (clk),
        .we    (cell_valid_reg),
        .waddr (cell_col_reg),
        .wdata (cell_value),
        .raddr (col_reg - ADDR_W'(1)),
        .rdata (prev_rd)
    );

    // With two columns the first read of a row hits the entry that is being
    // written in the same cycle, so the written value is forwarded.
    assign prev_val = fwd_hit_reg ? fwd_data_reg : prev_rd;

    // The first row and the first column have no diagonal neighbor, so the
    // row buffer never needs clearing.
    assign diag = (cell_first_row_reg || cell_col_reg == '0) ? '0 : prev_val;
    assign cell_value = (a_rd == b_rd) ? diag + CNT_W'(1) : '0;

    assign sts.seq_empty = (a_count_reg == '0) || (b_count_reg == '0);
    assign sts.cell_last = (col_reg == '0) && (CNT_W'(row_reg) + CNT_W'(1) == a_count_reg);
    assign sts.pipe_busy = cell_valid_reg;

    assign match_length = match_length_reg;
    assign dropped      = dropped_reg;

    always_comb
    begin
        a_count_next = a_count_reg;
        b_count_next = b_count_reg;
        flag_next    = flag_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        best_next    = best_reg;
        if (a_we)
        begin
            a_count_next = a_count_reg + CNT_W'(1);
        end
        if (b_we)
        begin
            b_count_next = b_count_reg + CNT_W'(1);
        end
        if ((ctl.append_a && !a_we) || (ctl.append_b && !b_we))
        begin
            flag_next = 1'b1;
        end
        if (ctl.start)
        begin
            row_next  = '0;
            col_next  = ADDR_W'(b_count_reg - CNT_W'(1));
            best_next = '0;
        end
        if (ctl.step)
        begin
            if (col_reg == '0)
            begin
                col_next = ADDR_W'(b_count_reg - CNT_W'(1));
                row_next = row_reg + ADDR_W'(1);
            end
            else
            begin
                col_next = col_reg - ADDR_W'(1);
            end
        end
        if (cell_valid_reg && cell_value > best_reg)
        begin
            best_next = cell_value;
        end
        if (ctl.finish)
        begin
            a_count_next = '0;
            b_count_next = '0;
            flag_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_count_reg    <= '0;
            b_count_reg    <= '0;
            flag_reg       <= 1'b0;
            best_reg       <= '0;
            cell_valid_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            a_count_reg    <= a_count_next;
            b_count_reg    <= b_count_next;
            flag_reg       <= flag_next;
            best_reg       <= best_next;
            cell_valid_reg <= ctl.step;
            fwd_hit_reg    <= cell_valid_reg && (cell_col_reg == col_reg - ADDR_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg            <= row_next;
        col_reg            <= col_next;
        cell_col_reg       <= col_reg;
        cell_first_row_reg <= (row_reg == '0);
        fwd_data_reg       <= cell_value;
        if (ctl.finish)
        begin
            match_length_reg <= LEN_W'(best_reg);
            dropped_reg      <= flag_reg;
        end
    end

endmodule

FILE: src/longest_common_run_length_top.sv
`timescale 1ns / 1ps
// Appends may arrive back to back.
// A compute walks all N*M cells of the table and then presents its result (with no walk
// if a sequence is empty); one cell of the table is formed per cycle by the datapath.
// Input stalls while a compute runs, and a new compute waits for the last result.
// rst_n is asynchronous and active low; it empties both sequences and the drop flag.
module longest_common_run_length_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  cmd,
    input  logic signed [31:0]          value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lcrl_pkg::LEN_W-1:0]  match_length,
    output logic                        dropped
);
    import lcrl_pkg::*;

    // The controller decodes each accepted transaction and sequences the
    // table walk; the datapath holds the sequence memories, the row buffer,
    // the counters and the result registers.
    lcrl_cmd_t    ctl;
    lcrl_status_t sts;

    lcrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    // Each cell reads the B element and the diagonal entry through registered RAM ports,
    // then writes its value back into the row buffer in the following cycle.
    lcrl_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .ctl          (ctl),
        .sts          (sts),
        .match_length (match_length),
        .dropped      (dropped)
    );

endmodule

FILE: src/lcrl_checker.sv
`timescale 1ns / 1ps
module lcrl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [1:0]                 cmd,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [lcrl_pkg::LEN_W-1:0] match_length,
    input logic                       dropped
);
    import lcrl_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(match_length) && $stable(dropped))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_COMPUTE |=> in_stall)
        else $error("input not stalled after compute");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> match_length <= LEN_W'(MAX_LEN))
        else $error("match length beyond sequence capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a compute in progress");

endmodule

bind longest_common_run_length_top lcrl_checker u_lcrl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .match_length (match_length),
    .dropped      (dropped)
);
